[hw/rtl/mbet_pkg.sv]
package mbet_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_MUL_RR,
    ST_MUL_II,
    ST_MUL_RI,
    ST_UPDATE,
    ST_FINISH
  } mbet_state_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_OFFSET = 2'd1;

  localparam logic [9:0]  GRID_RESET   = 10'd64;
  localparam logic [9:0]  GRID_MIN     = 10'd2;
  localparam logic [27:0] OFFSET_RESET = 28'd0;

  localparam int FRAC_BITS = 26;
  localparam int DIV_BITS  = 38;
  localparam int REM_W     = 11;
  localparam logic [5:0] DIV_LAST = 6'd37;

  // twice the window width of 3.5 in Q6.26
  localparam logic [DIV_BITS-1:0] WIN_W2 = 38'd469762048;

  localparam logic signed [39:0] RE_MIN  = -40'sd150994944;
  localparam logic signed [39:0] IM_MIN  = -40'sd117440512;
  localparam logic signed [39:0] BOX_POS = 40'sd134217728;
  localparam logic signed [39:0] BOX_NEG = -40'sd134217728;
  localparam logic signed [39:0] Q_MAX   = 40'sd2147483647;
  localparam logic signed [39:0] Q_MIN   = -40'sd2147483648;

endpackage

[hw/rtl/mandelbrot_escape_time_top.sv]
// Two 38-step restoring divisions map the pixel, then each iteration steps through
// ST_MUL_RR, ST_MUL_II, ST_MUL_RI and ST_UPDATE using one shared 32x32 multiplier.
// A new pixel is taken only after the last result is loaded into the output
// register, which waits while out_tready is low;
// in_tready is high only while the sequencer idles.
// Reset (rst_n low, synchronous): grid_size 64, window_offset 0, no result pending.
module mandelbrot_escape_time_top #(
  parameter int MAX_GRID        = 512,
  parameter int ITERATION_LIMIT = 400
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // pixel_row[8:0], pixel_column[17:9]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,  // escape_count[8:0], result_address[26:9]
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbet_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [27:0]                   cfg_data
);
  import mbet_pkg::*;

  localparam int IW = $clog2(ITERATION_LIMIT + 1);

  mbet_state_t state_r, state_nxt;
  logic [9:0]  grid_r, grid_nxt;
  logic [27:0] offset_r, offset_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [8:0]            row_r, row_nxt;
  logic [17:0]           addr_r, addr_nxt;
  logic [DIV_BITS-1:0]   dvd_r, dvd_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [5:0]            cnt_r, cnt_nxt;
  logic signed [31:0]    cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [31:0]    zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [37:0]    sq_re_r, sq_re_nxt, sq_im_r, sq_im_nxt, cross_r, cross_nxt;
  logic [IW-1:0]         iter_r, iter_nxt, res_r, res_nxt;
  logic [8:0]            out_count_r, out_count_nxt;
  logic [17:0]           out_addr_r, out_addr_nxt;

  logic [8:0]            in_row, in_col;
  logic [18:0]           addr_full;
  logic [REM_W-1:0]      divisor;
  logic [REM_W:0]        rem_sh, rem_diff;
  logic                  div_ge;
  logic [REM_W-1:0]      rem_step;
  logic [DIV_BITS-1:0]   dvd_step;
  logic signed [31:0]    mul_a, mul_b;
  logic signed [63:0]    prod;
  logic signed [37:0]    prod_floor;
  logic signed [39:0]    nr, ni;
  logic                  escape;
  logic [IW+8:0]         count_ext;
  logic [9:0]            grid_wr;

  function automatic logic [DIV_BITS-1:0] dividend(input logic [8:0] p, input logic [9:0] g);
    logic [9:0] s;
    s = g - 10'd1;
    return DIV_BITS'(p) * WIN_W2 + DIV_BITS'(s);
  endfunction

  function automatic logic signed [31:0] sat_coord(input logic signed [39:0] lo,
                                                   input logic [27:0] off,
                                                   input logic [DIV_BITS-1:0] q);
    logic signed [39:0] sum;
    sum = lo + $signed({12'd0, off}) + $signed({2'd0, q});
    if (sum > Q_MAX) return Q_MAX[31:0];
    if (sum < Q_MIN) return Q_MIN[31:0];
    return sum[31:0];
  endfunction

  assign in_row     = in_tdata[8:0];
  assign in_col     = in_tdata[17:9];
  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_addr_r, out_count_r};

  assign addr_full = 19'(in_col) * 19'(grid_r) + 19'(in_row);

  // one restoring division step
  assign divisor  = {grid_r - 10'd1, 1'b0};
  assign rem_sh   = {rem_r, dvd_r[DIV_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign div_ge   = (rem_sh >= {1'b0, divisor});
  assign rem_step = div_ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
  assign dvd_step = {dvd_r[DIV_BITS-2:0], div_ge};

  always_comb begin
    case (state_r)
      ST_MUL_II: begin
        mul_a = zi_r;
        mul_b = zi_r;
      end
      ST_MUL_RI: begin
        mul_a = zr_r;
        mul_b = zi_r;
      end
      default: begin
        mul_a = zr_r;
        mul_b = zr_r;
      end
    endcase
  end

  assign prod       = mul_a * mul_b;
  assign prod_floor = prod[63:FRAC_BITS];

  assign nr = 40'(sq_re_r) - 40'(sq_im_r) + 40'(cr_r);
  assign ni = (40'(cross_r) <<< 1) + 40'(ci_r);
  assign escape = (nr < BOX_NEG) || (nr > BOX_POS) || (ni < BOX_NEG) || (ni > BOX_POS);

  assign count_ext = {9'd0, res_r};
  assign grid_wr   = cfg_data[9:0];

  always_comb begin
    state_nxt     = state_r;
    grid_nxt      = grid_r;
    offset_nxt    = offset_r;
    out_valid_nxt = out_valid_r && !out_tready;
    row_nxt       = row_r;
    addr_nxt      = addr_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    sq_re_nxt     = sq_re_r;
    sq_im_nxt     = sq_im_r;
    cross_nxt     = cross_r;
    iter_nxt      = iter_r;
    res_nxt       = res_r;
    out_count_nxt = out_count_r;
    out_addr_nxt  = out_addr_r;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_GRID_SIZE: begin
          if (grid_wr >= GRID_MIN && 32'(grid_wr) <= 32'(MAX_GRID)) grid_nxt = grid_wr;
        end
        CFG_WINDOW_OFFSET: offset_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          row_nxt   = in_row;
          addr_nxt  = addr_full[17:0];
          dvd_nxt   = dividend(in_col, grid_r);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV_RE;
        end
      end
      ST_DIV_RE: begin
        rem_nxt = rem_step;
        dvd_nxt = dvd_step;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          cr_nxt    = sat_coord(RE_MIN, offset_r, dvd_step);
          dvd_nxt   = dividend(row_r, grid_r);
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV_IM;
        end
      end
      ST_DIV_IM: begin
        rem_nxt = rem_step;
        dvd_nxt = dvd_step;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          ci_nxt    = sat_coord(IM_MIN, offset_r, dvd_step);
          zi_nxt    = sat_coord(IM_MIN, offset_r, dvd_step);
          zr_nxt    = cr_r;
          iter_nxt  = IW'(1);
          state_nxt = ST_MUL_RR;
        end
      end
      ST_MUL_RR: begin
        sq_re_nxt = prod_floor;
        state_nxt = ST_MUL_II;
      end
      ST_MUL_II: begin
        sq_im_nxt = prod_floor;
        state_nxt = ST_MUL_RI;
      end
      ST_MUL_RI: begin
        cross_nxt = prod_floor;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (escape) begin
          res_nxt   = iter_r;
          state_nxt = ST_FINISH;
        end else if (iter_r == IW'(ITERATION_LIMIT)) begin
          res_nxt   = '0;
          state_nxt = ST_FINISH;
        end else begin
          iter_nxt  = iter_r + IW'(1);
          zr_nxt    = nr[31:0];
          zi_nxt    = ni[31:0];
          state_nxt = ST_MUL_RR;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_count_nxt = count_ext[8:0];
          out_addr_nxt  = addr_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      grid_r      <= GRID_RESET;
      offset_r    <= OFFSET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grid_r      <= grid_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    addr_r      <= addr_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    sq_re_r     <= sq_re_nxt;
    sq_im_r     <= sq_im_nxt;
    cross_r     <= cross_nxt;
    iter_r      <= iter_nxt;
    res_r       <= res_nxt;
    out_count_r <= out_count_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_DIV_RE))
    else $error("accepted request did not start the real-axis division");

  a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_RE || state_r == ST_DIV_IM) |-> (cnt_r <= DIV_LAST))
    else $error("division step count overran");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |-> (iter_r != '0 && iter_r <= IW'(ITERATION_LIMIT)))
    else $error("iteration count out of range");

  a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_valid_r && !out_tready) |=> (state_r == ST_FINISH))
    else $error("pending result overwritten");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input ready while a pixel is in progress");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
  import mbet_pkg::*;

  localparam int TB_MAX_GRID   = 512;
  localparam int TB_ITER_LIMIT = 400;
  localparam int RAND_PIXELS   = 850;
  localparam int HOLD_CYCLES   = 5000;
  localparam int HOLD_AFTER    = 150;
  localparam int MAX_PRINTS    = 60;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

  localparam longint RE_LO  = -150994944;
  localparam longint RE_HI  = 83886080;
  localparam longint IM_LO  = -117440512;
  localparam longint IM_HI  = 117440512;
  localparam longint ESC_LIM = 134217728;
  localparam longint SAT_HI = 2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [17:0] addr;
    logic [8:0]  count;
  } pix_result_t;

  typedef enum bit {ROW_PIXEL, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [27:0]           val;
    logic [8:0]            row;
    logic [8:0]            col;
    bit                    typed;
    pix_result_t           res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;   // pixel_row[8:0], pixel_column[17:9]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;  // escape_count[8:0], result_address[26:9]
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [27:0]          cfg_data;

  logic [9:0]   grid_q;
  logic [27:0]  offset_q;
  pix_result_t  pix_expected[$];
  pix_result_t  want_res;
  int           err_cnt = 0;
  int           burst_left = 0;

  int           rx_seen = 0;
  int           rx_cyc = 0;
  int           rx_mode = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;

  mandelbrot_escape_time_top #(
    .MAX_GRID       (TB_MAX_GRID),
    .ITERATION_LIMIT(TB_ITER_LIMIT)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("mandelbrot_escape_time_top test failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) $display("ERROR %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  function automatic longint map_axis(input logic [8:0] pos, input longint lo,
                                      input longint hi);
    longint s, p, off, num, n, d, q;
    s = grid_q;
    s = s - 1;
    p = pos;
    off = offset_q;
    num = p * (hi + off) + (s - p) * (lo + off);
    n = 2 * num + s;
    d = 2 * s;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q;
  endfunction

  function automatic pix_result_t escape_time(input logic [8:0] row, input logic [8:0] col);
    longint cr, ci, zr, zi, nr, ni;
    int k, addr_i, row_i, col_i, grid_i;
    bit escaped;
    pix_result_t res;
    cr = map_axis(col, RE_LO, RE_HI);
    ci = map_axis(row, IM_LO, IM_HI);
    zr = cr;
    zi = ci;
    escaped = 1'b0;
    res.count = '0;
    for (k = 1; k <= TB_ITER_LIMIT && !escaped; k++) begin
      nr = fx_mul(zr, zr) - fx_mul(zi, zi) + cr;
      ni = 2 * fx_mul(zr, zi) + ci;
      if (nr < -ESC_LIM || nr > ESC_LIM || ni < -ESC_LIM || ni > ESC_LIM) begin
        res.count = k[8:0];
        escaped = 1'b1;
      end
      zr = nr;
      zi = ni;
    end
    row_i = row;
    col_i = col;
    grid_i = grid_q;
    addr_i = row_i + col_i * grid_i;
    res.addr = addr_i[17:0];
    return res;
  endfunction

  task automatic send_pixel(input logic [8:0] row, input logic [8:0] col, input bit typed,
                            input pix_result_t typed_res);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      case ($urandom_range(0, 19))
        0:       gap = $urandom_range(1, 1800);
        1, 2, 3: gap = $urandom_range(1, 300);
        4, 5:    gap = 0;
        default: gap = $urandom_range(1, 8);
      endcase
      burst_left = $urandom_range(1, 20);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, col, row};
    do @(posedge clk); while (!in_tready);
    pix_expected.push_back(typed ? typed_res : escape_time(row, col));
    burst_left--;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [27:0] val);
    in_tvalid <= 1'b0;
    while (pix_expected.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GRID_SIZE: begin
        if (val[9:0] >= GRID_MIN && val[9:0] <= TB_MAX_GRID) grid_q = val[9:0];
      end
      CFG_WINDOW_OFFSET: offset_q = val;
      default: ;
    endcase
  endtask

  function automatic dir_row_t pix_row(input logic [8:0] row, input logic [8:0] col,
                                       input bit typed, input logic [8:0] cnt,
                                       input logic [17:0] addr);
    dir_row_t r;
    r = '0;
    r.kind = ROW_PIXEL;
    r.row = row;
    r.col = col;
    r.typed = typed;
    r.res.count = cnt;
    r.res.addr = addr;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [27:0] val);
    dir_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (out_tvalid && out_tready) rx_seen <= rx_seen + 1;
      if (rx_cyc % 200 == 0) rx_mode <= $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && rx_seen >= HOLD_AFTER) begin
        hold_left  <= HOLD_CYCLES;
        hold_done  <= 1'b1;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= rx_cyc[5];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pix_expected.size() == 0) begin
        report_mismatch($sformatf("result %h with no request pending", out_tdata));
      end else begin
        want_res = pix_expected.pop_front();
        if (out_tdata[8:0] !== want_res.count)
          report_mismatch($sformatf("escape_count %0d, expected %0d",
                                    out_tdata[8:0], want_res.count));
        if (out_tdata[26:9] !== want_res.addr)
          report_mismatch($sformatf("result_address %0d, expected %0d",
                                    out_tdata[26:9], want_res.addr));
      end
    end
  end

  initial begin : stimulus
    dir_row_t    dir_tab[$];
    int          sent, plen, j;
    logic [8:0]  r, c;
    logic [27:0] gdata, odata;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    grid_q    = GRID_RESET;
    offset_q  = OFFSET_RESET;

    dir_tab.push_back(pix_row(9'd0,   9'd0,   1'b1, 9'd1, 18'd0));
    dir_tab.push_back(pix_row(9'd511, 9'd511, 1'b1, 9'd1, 18'd33215));
    dir_tab.push_back(pix_row(9'd32,  9'd16,  1'b0, 9'd0, 18'd0));
    dir_tab.push_back(pix_row(9'd31,  9'd36,  1'b0, 9'd0, 18'd0));
    dir_tab.push_back(pix_row(9'd20,  9'd45,  1'b0, 9'd0, 18'd0));
    dir_tab.push_back(cfg_row(CFG_GRID_SIZE, 28'd2));
    dir_tab.push_back(pix_row(9'd1,   9'd1,   1'b1, 9'd1, 18'd3));
    dir_tab.push_back(pix_row(9'd0,   9'd1,   1'b0, 9'd0, 18'd0));
    dir_tab.push_back(pix_row(9'd511, 9'd511, 1'b1, 9'd1, 18'd1533));
    dir_tab.push_back(cfg_row(CFG_GRID_SIZE, 28'd0));
    dir_tab.push_back(cfg_row(CFG_GRID_SIZE, 28'd1));
    dir_tab.push_back(cfg_row(CFG_GRID_SIZE, 28'd513));
    dir_tab.push_back(cfg_row(CFG_GRID_SIZE, 28'd1023));
    dir_tab.push_back(cfg_row(CFG_IDX_SPARE2, 28'hFFFFFFF));
    dir_tab.push_back(cfg_row(CFG_IDX_SPARE3, 28'h5A5A5A5));
    dir_tab.push_back(pix_row(9'd1,   9'd0,   1'b0, 9'd0, 18'd0));
    dir_tab.push_back(cfg_row(CFG_GRID_SIZE, 28'd512));
    dir_tab.push_back(pix_row(9'd511, 9'd511, 1'b1, 9'd1, 18'd262143));
    dir_tab.push_back(pix_row(9'd0,   9'd511, 1'b1, 9'd1, 18'd261632));
    dir_tab.push_back(pix_row(9'd256, 9'd320, 1'b0, 9'd0, 18'd0));
    dir_tab.push_back(pix_row(9'd300, 9'd200, 1'b0, 9'd0, 18'd0));
    dir_tab.push_back(cfg_row(CFG_WINDOW_OFFSET, 28'hFFFFFFF));
    dir_tab.push_back(pix_row(9'd0,   9'd0,   1'b1, 9'd1, 18'd0));
    dir_tab.push_back(pix_row(9'd100, 9'd40,  1'b0, 9'd0, 18'd0));
    dir_tab.push_back(cfg_row(CFG_WINDOW_OFFSET, 28'h8000000));
    dir_tab.push_back(pix_row(9'd10,  9'd5,   1'b0, 9'd0, 18'd0));
    dir_tab.push_back(cfg_row(CFG_WINDOW_OFFSET, 28'h0400000));
    dir_tab.push_back(cfg_row(CFG_GRID_SIZE, 28'hFFFFC40));
    dir_tab.push_back(pix_row(9'd30,  9'd40,  1'b0, 9'd0, 18'd0));
    dir_tab.push_back(pix_row(9'd63,  9'd0,   1'b0, 9'd0, 18'd0));
    dir_tab.push_back(cfg_row(CFG_WINDOW_OFFSET, 28'd0));
    dir_tab.push_back(pix_row(9'd64,  9'd64,  1'b0, 9'd0, 18'd0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG)
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      else
        send_pixel(dir_tab[i].row, dir_tab[i].col, dir_tab[i].typed, dir_tab[i].res);
    end

    sent = 0;
    while (sent < RAND_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       gdata = 28'd2;
        1:       gdata = 28'd512;
        2:       gdata = 28'($urandom_range(2, 8));
        3:       gdata = 28'($urandom);
        default: gdata = 28'($urandom_range(2, 512));
      endcase
      case ($urandom_range(0, 9))
        0:       odata = 28'd0;
        1:       odata = 28'hFFFFFFF;
        2:       odata = 28'h8000000;
        3:       odata = 28'($urandom);
        default: odata = 28'($urandom_range(0, 50331648));
      endcase
      write_reg(CFG_GRID_SIZE, gdata);
      write_reg(CFG_WINDOW_OFFSET, odata);
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE2 : CFG_IDX_SPARE3, 28'($urandom));
      plen = $urandom_range(20, 70);
      for (j = 0; j < plen && sent < RAND_PIXELS; j++) begin
        if ($urandom_range(0, 6) == 0) begin
          r = 9'($urandom);
          c = 9'($urandom);
        end else begin
          r = 9'($urandom_range(0, grid_q - 1));
          c = 9'($urandom_range(0, grid_q - 1));
        end
        send_pixel(r, c, 1'b0, '0);
        sent++;
      end
    end

    in_tvalid <= 1'b0;
    while (pix_expected.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_cnt == 0)
      $display("mandelbrot_escape_time_top test passed");
    else
      $display("mandelbrot_escape_time_top test failed");
    $finish;
  end

endmodule
